// File: rtl/mirror_free_permutation_generator_top_defines.svh
`ifndef MIRROR_FREE_PERMUTATION_GENERATOR_TOP_DEFINES_SVH
`define MIRROR_FREE_PERMUTATION_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MFPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MFPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfpg_pkg.sv
package mfpg_pkg;

    // Default element count limit
    localparam int MAX_N_DEF    = 8;
    // Width and reset value of the element count register
    localparam int N_USED_W     = 4;
    localparam logic [N_USED_W-1:0] N_USED_RESET = 4'd4;
    // Packed output word: one nibble per element, eight nibbles
    localparam int PERM_WORD_W  = 32;
    localparam int NIBBLE_W     = 4;
    localparam int PACK_SLOTS   = 8;
    // Stream data widths
    localparam int S_TDATA_W    = 8;

    // Command from the top level to the search unit
    typedef struct packed {
        logic go;     // start a successor search
        logic init;   // load 1..n first, then search
    } srch_cmd_t;

    // Status from the search unit
    typedef struct packed {
        logic done;   // one-cycle pulse at end of search
        logic found;  // a kept successor is now in the slots
    } srch_stat_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_SEARCH,
        TS_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        ES_IDLE,
        ES_TRY,
        ES_FILL,
        ES_CHECK
    } srch_state_t;

endpackage

// File: rtl/mfpg_search.sv
`include "mirror_free_permutation_generator_top_defines.svh"

module mfpg_search
    import mfpg_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [$clog2(MAX_N+1)-1:0]                 n_eff,
    input  srch_cmd_t                                  cmd,
    output srch_stat_t                                 stat,
    output logic [MAX_N-1:0][$clog2(MAX_N+1)-1:0]      slots
);

    localparam int ELEM_W = $clog2(MAX_N + 1);
    localparam int LVL_W  = ELEM_W;
    localparam int IDX_W  = $clog2(MAX_N);

    srch_state_t                     state_reg, state_next;
    logic [MAX_N-1:0][ELEM_W-1:0]    w_reg, w_next;
    logic [MAX_N-1:0]                mask_reg, mask_next;
    logic [LVL_W-1:0]                t_reg, t_next;

    logic [LVL_W-1:0]                t_m1, t_m2, n_m1;
    logic [IDX_W-1:0]                t_idx, p_idx, last_idx;
    logic [ELEM_W-1:0]               thr;
    logic                            hit;
    logic [ELEM_W-1:0]               hit_val;
    logic                            kept;
    logic                            t_at_n, t_at_one;
    logic [MAX_N-1:0][ELEM_W-1:0]    ident;
    logic [MAX_N-1:0]                full_n;

    // one-hot mask bit of value v (values start at 1)
    function automatic logic [MAX_N-1:0] val_bit(input logic [ELEM_W-1:0] v);
        val_bit = MAX_N'(1) << (v - ELEM_W'(1));
    endfunction

    // level indexes
    assign t_m1     = t_reg - LVL_W'(1);
    assign t_m2     = t_reg - LVL_W'(2);
    assign n_m1     = n_eff - LVL_W'(1);
    assign t_idx    = t_m1[IDX_W-1:0];
    assign p_idx    = t_m2[IDX_W-1:0];
    assign last_idx = n_m1[IDX_W-1:0];
    assign t_at_n   = (t_reg == n_eff);
    assign t_at_one = (t_reg == LVL_W'(1));
    assign kept     = (w_reg[0] <= w_reg[last_idx]);
    assign slots    = w_reg;

    // identity permutation and full mask for n
    always_comb
    begin
        for (int i = 0; i < MAX_N; i++)
        begin
            ident[i]  = (i < int'(n_eff)) ? ELEM_W'(i + 1) : '0;
            full_n[i] = (i < int'(n_eff));
        end
    end

    // shared unit: smallest free value above thr, up to n
    assign thr = (state_reg == ES_FILL) ? '0 : w_reg[t_idx];

    always_comb
    begin
        hit     = 1'b0;
        hit_val = '0;
        for (int i = MAX_N - 1; i >= 0; i--)
        begin
            if (!mask_reg[i] && (i < int'(n_eff)) && (i >= int'(thr)))
            begin
                hit     = 1'b1;
                hit_val = ELEM_W'(i + 1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ES_IDLE:
            begin
                if (cmd.go)
                    state_next = ES_TRY;
            end
            ES_TRY:
            begin
                if (hit)
                    state_next = t_at_n ? ES_CHECK : ES_FILL;
                else if (t_at_one)
                    state_next = ES_IDLE;
            end
            ES_FILL:
            begin
                if (t_at_n)
                    state_next = ES_CHECK;
            end
            ES_CHECK:
            begin
                state_next = kept ? ES_IDLE : ES_TRY;
            end
            default:
            begin
                state_next = ES_IDLE;
            end
        endcase
    end

    // slot, mask and level updates
    always_comb
    begin
        w_next    = w_reg;
        mask_next = mask_reg;
        t_next    = t_reg;
        case (state_reg)
            ES_IDLE:
            begin
                if (cmd.go)
                begin
                    t_next = n_eff;
                    if (cmd.init)
                    begin
                        w_next    = ident;
                        mask_next = full_n & ~val_bit(ELEM_W'(n_eff));
                    end
                    else
                    begin
                        mask_next = mask_reg & ~val_bit(w_reg[last_idx]);
                    end
                end
            end
            ES_TRY:
            begin
                if (hit)
                begin
                    w_next[t_idx] = hit_val;
                    mask_next     = mask_reg | val_bit(hit_val);
                    if (!t_at_n)
                        t_next = t_reg + LVL_W'(1);
                end
                else if (!t_at_one)
                begin
                    // back up one level and release its value
                    t_next    = t_m1;
                    mask_next = mask_reg & ~val_bit(w_reg[p_idx]);
                end
            end
            ES_FILL:
            begin
                w_next[t_idx] = hit_val;
                mask_next     = mask_reg | val_bit(hit_val);
                if (!t_at_n)
                    t_next = t_reg + LVL_W'(1);
            end
            ES_CHECK:
            begin
                // mirror duplicate: search on from the last level
                if (!kept)
                    mask_next = mask_reg & ~val_bit(w_reg[last_idx]);
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    // status
    always_comb
    begin
        stat.done  = ((state_reg == ES_TRY) && !hit && t_at_one) ||
                     ((state_reg == ES_CHECK) && kept);
        stat.found = (state_reg == ES_CHECK) && kept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ES_IDLE;
            t_reg     <= LVL_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= '0;
            mask_reg <= '0;
        end
        else
        begin
            w_reg    <= w_next;
            mask_reg <= mask_next;
        end
    end

    `MFPG_ASSERT_IMP(a_go_when_idle, cmd.go, state_reg == ES_IDLE, "search started while busy")
    `MFPG_ASSERT_IMP(a_fill_hits, state_reg == ES_FILL, hit, "fill found no free value")
    `MFPG_ASSERT_NXT(a_done_idle, stat.done, state_reg == ES_IDLE, "search did not stop")

endmodule

// File: rtl/mirror_free_permutation_generator_top.sv
// Each successor tried backs over b levels (1 to n-1) and refills them; mirror rejects
// repeat that, and a walk that runs out backs up to level 1. A not-found answer raises
// m_tvalid in the cycle after accept.
// Throughput: one request at a time; s_tready is low from accept until the result word is
// taken. Reset (rst_n, async, low) sets n to 4, clears started and the result word.
`include "mirror_free_permutation_generator_top_defines.svh"

module mirror_free_permutation_generator_top
    import mfpg_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config
    input  logic                   cfg_we,
    input  logic [N_USED_W-1:0]    cfg_wdata,     // n_used
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,       // [0] restart, rest zero
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PERM_WORD_W-1:0] m_tdata,       // [31:0] perm_word
    output logic [0:0]             m_tuser,       // [0] found
    output logic                   m_tlast        // last
);

    localparam int ELEM_W = $clog2(MAX_N + 1);
    localparam int LVL_W  = ELEM_W;
    localparam int PACK_N = (MAX_N < PACK_SLOTS) ? MAX_N : PACK_SLOTS;

    top_state_t                      state_reg, state_next;
    logic                            started_reg, exhausted_reg, next_ok_reg;
    logic [LVL_W-1:0]                n_eff_reg;
    logic [PERM_WORD_W-1:0]          perm_word_reg;
    logic                            found_reg, last_reg;

    logic                            accept, fresh, launch;
    srch_cmd_t                       cmd;
    srch_stat_t                      stat;
    logic [MAX_N-1:0][ELEM_W-1:0]    slots;

    // saturate n to 1..MAX_N
    function automatic logic [LVL_W-1:0] sat_n(input logic [N_USED_W-1:0] v);
        if (v == '0)
            sat_n = LVL_W'(1);
        else if (int'(v) > MAX_N)
            sat_n = LVL_W'(MAX_N);
        else
            sat_n = LVL_W'(v);
    endfunction

    // pack slots, one nibble per element, nibbles above n zero
    function automatic logic [PERM_WORD_W-1:0] pack_slots(
        input logic [MAX_N-1:0][ELEM_W-1:0] s,
        input logic [LVL_W-1:0]             n
    );
        logic [PERM_WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < PACK_N; i++)
        begin
            if (i < int'(n))
                w[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'(s[i]);
        end
        pack_slots = w;
    endfunction

    // packed identity 1..n
    function automatic logic [PERM_WORD_W-1:0] pack_ident(input logic [LVL_W-1:0] n);
        logic [PERM_WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < PACK_N; i++)
        begin
            if (i < int'(n))
                w[NIBBLE_W*i +: NIBBLE_W] = NIBBLE_W'(i + 1);
        end
        pack_ident = w;
    endfunction

    // request decode
    assign accept   = s_tvalid && s_tready;
    assign fresh    = s_tdata[0] || !started_reg;
    assign launch   = accept && (fresh || (!exhausted_reg && next_ok_reg));
    assign cmd.go   = launch;
    assign cmd.init = fresh;

    mfpg_search #(
        .MAX_N (MAX_N)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .n_eff (n_eff_reg),
        .cmd   (cmd),
        .stat  (stat),
        .slots (slots)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (accept)
                    state_next = launch ? TS_SEARCH : TS_HOLD;
            end
            TS_SEARCH:
            begin
                if (stat.done)
                    state_next = TS_HOLD;
            end
            TS_HOLD:
            begin
                if (m_tready)
                    state_next = TS_IDLE;
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == TS_IDLE);
        m_tvalid = (state_reg == TS_HOLD);
        m_tdata  = perm_word_reg;
        m_tuser  = found_reg;
        m_tlast  = last_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            next_ok_reg   <= 1'b0;
            n_eff_reg     <= sat_n(N_USED_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                n_eff_reg     <= sat_n(cfg_wdata);
                started_reg   <= 1'b0;
                exhausted_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (fresh)
                begin
                    started_reg   <= 1'b1;
                    exhausted_reg <= 1'b0;
                end
                else if (!launch)
                begin
                    exhausted_reg <= 1'b1;
                end
            end
            if (stat.done)
                next_ok_reg <= stat.found;
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
            perm_word_reg <= '0;
        end
        else if (accept)
        begin
            found_reg <= launch;
            last_reg  <= 1'b0;
            if (!launch)
                perm_word_reg <= '0;
            else if (fresh)
                perm_word_reg <= pack_ident(n_eff_reg);
            else
                perm_word_reg <= pack_slots(slots, n_eff_reg);
        end
        else if (stat.done)
        begin
            last_reg <= !stat.found;
        end
    end

    `MFPG_ASSERT_IMP(a_one_side, m_tvalid, !s_tready, "request taken while result pending")
    `MFPG_ASSERT_IMP(a_nf_clear, m_tvalid && !m_tuser, !m_tlast && m_tdata == '0, "word not clear")
    `MFPG_ASSERT_NXT(a_restart, accept && s_tdata[0], !s_tready && !m_tvalid, "restart skipped")

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb
    import mfpg_pkg::*;
();

    localparam int MAXN       = MAX_N_DEF;
    localparam int QUIET_MAX  = 3000;   // cycles with no handshake before giving up
    localparam int RAND_ITEMS = 1200;

    typedef logic [MAXN:0][NIBBLE_W-1:0] slot_arr_t;   // index 0 unused

    typedef struct {
        logic [PERM_WORD_W-1:0] word;
        logic                   found;
        logic                   fin;
    } perm_result_t;

    typedef struct {
        bit                  is_cfg;
        logic [N_USED_W-1:0] value;
        bit                  restart;
    } stim_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [N_USED_W-1:0]    cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PERM_WORD_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    // stimulus and expectations
    stim_word_t   stim_q[$];
    perm_result_t perms_due[$];

    // predictor state
    slot_arr_t         walk_slots = '0;
    logic [MAXN-1:0]   walk_used = '0;
    bit                walk_done = 1'b0;
    bit                walk_live = 1'b0;
    logic [N_USED_W-1:0] n_reg = N_USED_RESET;

    // bookkeeping
    bit req_taken = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int err_count = 0;
    int n_queued = 0;
    int n_requests = 0;
    int n_words = 0;
    int n_cfg = 0;
    int n_exhausted = 0;

    mirror_free_permutation_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [0] restart, rest zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [31:0] perm_word
        .m_tuser   (m_tuser),      // [0] found
        .m_tlast   (m_tlast)       // last
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // n register value as the block uses it
    function automatic int eff_count(logic [N_USED_W-1:0] r);
        if (r == 0)
            return 1;
        if (int'(r) > MAXN)
            return MAXN;
        return int'(r);
    endfunction

    // lexicographic successor of a full permutation; 0 when there is none
    function automatic bit advance_lex(inout slot_arr_t s, inout logic [MAXN-1:0] m,
                                       input int n);
        int t;
        int v;
        int k;
        bit placed;
        bit got;
        t = n;
        m[int'(s[t]) - 1] = 1'b0;
        while (t > 0)
        begin
            placed = 1'b0;
            for (v = int'(s[t]) + 1; v <= n && !placed; v++)
            begin
                if (!m[v-1])
                begin
                    s[t] = v[NIBBLE_W-1:0];
                    m[v-1] = 1'b1;
                    placed = 1'b1;
                end
            end
            if (placed)
            begin
                // fill the tail with the smallest free values
                for (k = t + 1; k <= n; k++)
                begin
                    got = 1'b0;
                    for (v = 1; v <= n && !got; v++)
                    begin
                        if (!m[v-1])
                        begin
                            s[k] = v[NIBBLE_W-1:0];
                            m[v-1] = 1'b1;
                            got = 1'b1;
                        end
                    end
                end
                return 1'b1;
            end
            t--;
            if (t > 0)
                m[int'(s[t]) - 1] = 1'b0;
        end
        return 1'b0;
    endfunction

    // next permutation whose first element does not exceed its last
    function automatic bit advance_kept(inout slot_arr_t s, inout logic [MAXN-1:0] m,
                                        input int n);
        while (advance_lex(s, m, n))
        begin
            if (s[1] <= s[n])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // one request against the predictor state
    function automatic perm_result_t serve_request(bit restart);
        perm_result_t res;
        slot_arr_t look;
        logic [MAXN-1:0] look_used;
        int n;
        int i;
        n = eff_count(n_reg);
        res.word = '0;
        res.found = 1'b0;
        res.fin = 1'b0;
        if (restart || !walk_live)
        begin
            walk_slots = '0;
            walk_used = '0;
            for (i = 1; i <= n; i++)
            begin
                walk_slots[i] = i[NIBBLE_W-1:0];
                walk_used[i-1] = 1'b1;
            end
            walk_live = 1'b1;
            walk_done = 1'b0;
        end
        else if (walk_done || !advance_kept(walk_slots, walk_used, n))
        begin
            walk_done = 1'b1;
            return res;
        end
        for (i = 1; i <= n && i <= PACK_SLOTS; i++)
            res.word[NIBBLE_W*(i-1) +: NIBBLE_W] = walk_slots[i];
        res.found = 1'b1;
        look = walk_slots;
        look_used = walk_used;
        res.fin = !advance_kept(look, look_used, n);
        return res;
    endfunction

    // mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cfg(logic [N_USED_W-1:0] v);
        stim_word_t w;
        w.is_cfg = 1'b1;
        w.value = v;
        w.restart = 1'b0;
        stim_q.push_back(w);
    endtask

    task automatic add_req(bit r);
        stim_word_t w;
        w.is_cfg = 1'b0;
        w.value = '0;
        w.restart = r;
        stim_q.push_back(w);
        n_queued++;
    endtask

    task automatic add_reqs(int count, int restart_pct);
        for (int i = 0; i < count; i++)
            add_req($urandom_range(0, 99) < restart_pct);
    endtask

    // request driver
    always @(negedge clk)
    begin
        stim_word_t w;
        logic valid_nx;
        logic we_nx;
        logic [N_USED_W-1:0] wdata_nx;
        logic [S_TDATA_W-1:0] data_nx;
        valid_nx = s_tvalid;
        we_nx = 1'b0;
        wdata_nx = cfg_wdata;
        data_nx = s_tdata;
        if (rst_n)
        begin
            if (s_tvalid && req_taken)
                valid_nx = 1'b0;
            if (!valid_nx)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_q.size() > 0)
                begin
                    if (stim_q[0].is_cfg)
                    begin
                        // register writes only once the block is idle
                        if (perms_due.size() == 0 && !s_tvalid)
                        begin
                            w = stim_q.pop_front();
                            we_nx = 1'b1;
                            wdata_nx = w.value;
                        end
                    end
                    else
                    begin
                        w = stim_q.pop_front();
                        valid_nx = 1'b1;
                        data_nx = '0;
                        data_nx[0] = w.restart;
                        if (burst_left > 0)
                            burst_left--;
                        else if ($urandom_range(0, 149) == 0)
                            burst_left = 60;
                        gap_left = pick_gap();
                    end
                end
            end
        end
        s_tvalid <= valid_nx;
        s_tdata <= data_nx;
        cfg_we <= we_nx;
        cfg_wdata <= wdata_nx;
    end

    // result receiver with random stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 15)
                stall_left = pick_gap();
        end
    end

    // monitor: predict on request, check on result, watchdog
    always @(posedge clk)
    begin
        perm_result_t exp_perm;
        if (rst_n)
        begin
            req_taken <= s_tvalid && s_tready;
            if (cfg_we)
            begin
                n_reg = cfg_wdata;
                walk_live = 1'b0;
                walk_done = 1'b0;
                n_cfg++;
            end
            if (s_tvalid && s_tready)
            begin
                perms_due.push_back(serve_request(s_tdata[0]));
                n_requests++;
            end
            if (m_tvalid && m_tready)
            begin
                n_words++;
                if (perms_due.size() == 0)
                begin
                    $error("result word with nothing expected: perm_word %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    exp_perm = perms_due.pop_front();
                    if (!exp_perm.found)
                        n_exhausted++;
                    if (m_tdata !== exp_perm.word)
                    begin
                        $error("perm_word: expected %h, got %h", exp_perm.word, m_tdata);
                        err_count++;
                    end
                    if (m_tuser[0] !== exp_perm.found)
                    begin
                        $error("found: expected %b, got %b", exp_perm.found, m_tuser[0]);
                        err_count++;
                    end
                    if (m_tlast !== exp_perm.fin)
                    begin
                        $error("last: expected %b, got %b", exp_perm.fin, m_tlast);
                        err_count++;
                    end
                end
            end
            if (cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_MAX);
                $display("mirror_free_permutation_generator_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int en;
        int cnt;
        bit first;
        logic [N_USED_W-1:0] v;

        // reset n of 4: first request acts as restart, walk runs out, restart
        add_reqs(14, 0);
        add_req(1'b1);
        add_req(1'b0);
        // n of zero saturates to one
        add_cfg(4'd0);
        add_req(1'b0);
        add_req(1'b0);
        add_req(1'b1);
        // n of one
        add_cfg(4'd1);
        add_req(1'b0);
        add_req(1'b0);
        // largest code saturates to the limit; restart in mid walk
        add_cfg(4'd15);
        add_req(1'b1);
        add_req(1'b0);
        add_req(1'b1);

        // random phases: small n walked to the end, large n partly
        first = 1'b1;
        while (n_queued < RAND_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (first)
                v = 4'd8;
            else if (r < 60)
                v = N_USED_W'($urandom_range(1, 5));
            else if (r < 85)
                v = N_USED_W'($urandom_range(6, 8));
            else
                v = N_USED_W'($urandom_range(0, 15));
            first = 1'b0;
            add_cfg(v);
            en = eff_count(v);
            if (en <= 5)
            begin
                cnt = 1;
                for (int i = 2; i <= en; i++)
                    cnt *= i;
                if (en > 1)
                    cnt /= 2;
                cnt += $urandom_range(1, 4);
            end
            else
                cnt = $urandom_range(10, 80);
            add_reqs(cnt, ($urandom_range(0, 3) == 0) ? 25 : 1);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain; the watchdog covers a hang
        while (stim_q.size() > 0 || s_tvalid || perms_due.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d requests and %0d result words over %0d n settings",
                 n_requests, n_words, n_cfg);
        $display("walks run past the end: %0d not-found answers", n_exhausted);
        if (err_count == 0 && perms_due.size() == 0)
            $display("mirror_free_permutation_generator_top regression: pass");
        else
            $display("mirror_free_permutation_generator_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mfpg_pkg.sv
rtl/mfpg_search.sv
rtl/mirror_free_permutation_generator_top.sv
test/tb.sv
